[design/sorted_unique_set_with_neighbours_defines.svh]
// Assertion macros for the sorted set block.
// Included by modules that carry concurrent assertions; needs clock and reset in scope.
`ifndef SORTED_UNIQUE_SET_WITH_NEIGHBOURS_DEFINES_SVH
`define SORTED_UNIQUE_SET_WITH_NEIGHBOURS_DEFINES_SVH

// Condition holds at every edge outside reset.
`define SUSN_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("sorted set: invariant violated");

// Antecedent at one edge implies consequent at the next.
`define SUSN_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted set: sequence violated");

`endif

[design/susn_pkg.sv]
// Shared constants, codes and state encoding for the sorted set block.
// No dependencies.
package susn_pkg;

   localparam int CAPACITY  = 64;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int DATA_W    = 32;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int NCOUNT_W  = 2;
   localparam int PRODUCT_W = 64;
   localparam int ECOUNT_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_DUPLICATE = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_CHECK_WAIT,
      ST_DECIDE,
      ST_INS_SHIFT,
      ST_INS_WAIT,
      ST_REM_SHIFT,
      ST_REM_WAIT,
      ST_Q_LEFT,
      ST_Q_LEFT_WAIT,
      ST_Q_RIGHT,
      ST_Q_RIGHT_WAIT,
      ST_Q_MUL,
      ST_RESP
   } state_type;

endpackage

[design/susn_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on susn_pkg for payload widths.
interface susn_req_if;
   logic                                valid;
   logic                                ready;
   logic [susn_pkg::OP_W-1:0]           operation;
   logic signed [susn_pkg::DATA_W-1:0]  value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface susn_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [susn_pkg::STATUS_W-1:0]         status;
   logic [susn_pkg::NCOUNT_W-1:0]         neighbour_count;
   logic signed [susn_pkg::PRODUCT_W-1:0] neighbour_product;
   logic [susn_pkg::ECOUNT_W-1:0]         entry_count;

   modport source (output valid, output status, output neighbour_count,
                   output neighbour_product, output entry_count, input ready);
   modport sink   (input valid, input status, input neighbour_count,
                   input neighbour_product, input entry_count, output ready);
endinterface

[design/susn_ram.sv]
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies; contents undefined until written.
module susn_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

[design/sorted_unique_set_with_neighbours.sv]
// Sorted set of signed 32-bit values held in one RAM with registered read data.
// Steps: binary search, RAM read and compare per probe (up to log2(CAPACITY)+1 probes),
// plus a found check, then insert/remove shift with a read and a write per moved entry
// (one RAM port) or query with neighbour reads and a registered multiply, then a response.
// Throughput: one transaction at a time; next request may be taken while a response waits.
// Reset: synchronous active high; clears count, FSM and response valid; RAM is not cleared.
`include "sorted_unique_set_with_neighbours_defines.svh"

module sorted_unique_set_with_neighbours (
   input logic         clock,
   input logic         reset,
   susn_req_if.sink    req_chan,
   susn_rsp_if.source  rsp_chan
);

   localparam int IDX_W = susn_pkg::IDX_W;
   localparam int CNT_W = susn_pkg::CNT_W;
   localparam int DW    = susn_pkg::DATA_W;

   // control state
   susn_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // transaction payload
   susn_pkg::op_type     op_ff, op_in;
   logic signed [DW-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;     // lower bound; ends as the position
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     mid_ff, mid_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;   // shift cursor
   logic                 found_ff, found_in;
   logic signed [DW-1:0] left_ff, left_in;
   logic signed [DW-1:0] right_ff, right_in;
   logic                 has_left_ff, has_left_in;
   logic                 has_right_ff, has_right_in;
   susn_pkg::status_type status_ff, status_in;
   logic [susn_pkg::NCOUNT_W-1:0]         ncount_ff, ncount_in;
   logic signed [susn_pkg::PRODUCT_W-1:0] product_ff, product_in;

   // response register
   logic [susn_pkg::STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [susn_pkg::NCOUNT_W-1:0]         rsp_ncount_ff, rsp_ncount_in;
   logic signed [susn_pkg::PRODUCT_W-1:0] rsp_product_ff, rsp_product_in;
   logic [susn_pkg::ECOUNT_W-1:0]         rsp_ecount_ff, rsp_ecount_in;

   // RAM port
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [DW-1:0]    ram_wdata, ram_rdata;

   logic             req_fire;
   logic             rsp_free;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] lo_plus1;
   logic [CNT_W-1:0] idx_plus1;
   logic signed [DW-1:0] mul_a, mul_b;

   assign req_chan.ready = (state_ff == susn_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CNT_W:1];
   assign lo_plus1  = lo_ff + CNT_W'(1);
   assign idx_plus1 = idx_ff + CNT_W'(1);
   // absent neighbour counts as a factor of one
   assign mul_a = has_left_ff  ? left_ff  : DW'(1);
   assign mul_b = has_right_ff ? right_ff : DW'(1);

   // Single port pair; where the FSM reads and writes the same entry in one cycle, the
   // read data is not used, so no forwarding is needed.
   susn_ram #(
      .DEPTH (susn_pkg::CAPACITY),
      .WIDTH (DW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         susn_pkg::ST_IDLE:        if (req_fire) state_in = susn_pkg::ST_SEARCH;
         susn_pkg::ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               state_in = susn_pkg::ST_SEARCH_WAIT;
            end else if (lo_ff < count_ff) begin
               state_in = susn_pkg::ST_CHECK_WAIT;
            end else begin
               state_in = susn_pkg::ST_DECIDE;
            end
         end
         susn_pkg::ST_SEARCH_WAIT: state_in = susn_pkg::ST_SEARCH;
         susn_pkg::ST_CHECK_WAIT:  state_in = susn_pkg::ST_DECIDE;
         susn_pkg::ST_DECIDE: begin
            state_in = susn_pkg::ST_RESP;
            case (op_ff)
               susn_pkg::OP_INSERT:
                  if (!found_ff && count_ff < CNT_W'(susn_pkg::CAPACITY))
                     state_in = susn_pkg::ST_INS_SHIFT;
               susn_pkg::OP_REMOVE: if (found_ff) state_in = susn_pkg::ST_REM_SHIFT;
               susn_pkg::OP_QUERY:  if (found_ff) state_in = susn_pkg::ST_Q_LEFT;
               default:             state_in = susn_pkg::ST_RESP;
            endcase
         end
         susn_pkg::ST_INS_SHIFT:
            state_in = (idx_ff > lo_ff) ? susn_pkg::ST_INS_WAIT : susn_pkg::ST_RESP;
         susn_pkg::ST_INS_WAIT:    state_in = susn_pkg::ST_INS_SHIFT;
         susn_pkg::ST_REM_SHIFT:
            state_in = (idx_plus1 < count_ff) ? susn_pkg::ST_REM_WAIT : susn_pkg::ST_RESP;
         susn_pkg::ST_REM_WAIT:    state_in = susn_pkg::ST_REM_SHIFT;
         susn_pkg::ST_Q_LEFT:
            state_in = (lo_ff != '0) ? susn_pkg::ST_Q_LEFT_WAIT : susn_pkg::ST_Q_RIGHT;
         susn_pkg::ST_Q_LEFT_WAIT: state_in = susn_pkg::ST_Q_RIGHT;
         susn_pkg::ST_Q_RIGHT:
            state_in = (lo_plus1 < count_ff) ? susn_pkg::ST_Q_RIGHT_WAIT
                                             : susn_pkg::ST_Q_MUL;
         susn_pkg::ST_Q_RIGHT_WAIT: state_in = susn_pkg::ST_Q_MUL;
         susn_pkg::ST_Q_MUL:       state_in = susn_pkg::ST_RESP;
         susn_pkg::ST_RESP:        if (rsp_free) state_in = susn_pkg::ST_IDLE;
         default:                  state_in = susn_pkg::ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      count_in       = count_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      has_left_in    = has_left_ff;
      has_right_in   = has_right_ff;
      status_in      = status_ff;
      ncount_in      = ncount_ff;
      product_in     = product_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_ncount_in  = rsp_ncount_ff;
      rsp_product_in = rsp_product_ff;
      rsp_ecount_in  = rsp_ecount_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff[IDX_W-1:0];
      ram_wdata      = ram_rdata;
      ram_raddr      = lo_ff[IDX_W-1:0];

      case (state_ff)
         susn_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in        = susn_pkg::op_type'(req_chan.operation);
               key_in       = req_chan.value;
               lo_in        = '0;
               hi_in        = count_ff;
               found_in     = 1'b0;
               has_left_in  = 1'b0;
               has_right_in = 1'b0;
               status_in    = susn_pkg::STATUS_OK;
               ncount_in    = '0;
               product_in   = susn_pkg::PRODUCT_W'(1);
            end
         end
         susn_pkg::ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_raddr = mid[IDX_W-1:0];
               mid_in    = mid;
            end
         end
         susn_pkg::ST_SEARCH_WAIT: begin
            if ($signed(ram_rdata) < key_ff) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
         end
         susn_pkg::ST_CHECK_WAIT:  found_in = ($signed(ram_rdata) == key_ff);
         susn_pkg::ST_DECIDE: begin
            case (op_ff)
               susn_pkg::OP_INSERT: begin
                  if (found_ff) begin
                     status_in = susn_pkg::STATUS_DUPLICATE;
                  end else if (count_ff >= CNT_W'(susn_pkg::CAPACITY)) begin
                     status_in = susn_pkg::STATUS_FULL;
                  end
                  idx_in = count_ff;
               end
               susn_pkg::OP_REMOVE: begin
                  if (!found_ff) status_in = susn_pkg::STATUS_NOT_FOUND;
                  idx_in = lo_ff;
               end
               susn_pkg::OP_QUERY:
                  if (!found_ff) status_in = susn_pkg::STATUS_NOT_FOUND;
               default: status_in = susn_pkg::STATUS_OK;
            endcase
         end
         susn_pkg::ST_INS_SHIFT: begin
            if (idx_ff > lo_ff) begin
               ram_raddr = idx_ff[IDX_W-1:0] - IDX_W'(1);
            end else begin
               ram_we    = 1'b1;
               ram_waddr = lo_ff[IDX_W-1:0];
               ram_wdata = key_ff;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         susn_pkg::ST_INS_WAIT: begin
            ram_we = 1'b1;
            idx_in = idx_ff - CNT_W'(1);
         end
         susn_pkg::ST_REM_SHIFT: begin
            if (idx_plus1 < count_ff) begin
               ram_raddr = idx_plus1[IDX_W-1:0];
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         susn_pkg::ST_REM_WAIT: begin
            ram_we = 1'b1;
            idx_in = idx_plus1;
         end
         susn_pkg::ST_Q_LEFT:      ram_raddr = lo_ff[IDX_W-1:0] - IDX_W'(1);
         susn_pkg::ST_Q_LEFT_WAIT: begin
            left_in     = ram_rdata;
            has_left_in = 1'b1;
         end
         susn_pkg::ST_Q_RIGHT:     ram_raddr = lo_plus1[IDX_W-1:0];
         susn_pkg::ST_Q_RIGHT_WAIT: begin
            right_in     = ram_rdata;
            has_right_in = 1'b1;
         end
         susn_pkg::ST_Q_MUL: begin
            product_in = susn_pkg::PRODUCT_W'(mul_a) * susn_pkg::PRODUCT_W'(mul_b);
            ncount_in  = susn_pkg::NCOUNT_W'(has_left_ff) + susn_pkg::NCOUNT_W'(has_right_ff);
         end
         susn_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_ncount_in  = ncount_ff;
               rsp_product_in = product_ff;
               rsp_ecount_in  = susn_pkg::ECOUNT_W'(count_ff);
            end
         end
         default: ram_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= susn_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      idx_ff         <= idx_in;
      found_ff       <= found_in;
      left_ff        <= left_in;
      right_ff       <= right_in;
      has_left_ff    <= has_left_in;
      has_right_ff   <= has_right_in;
      status_ff      <= status_in;
      ncount_ff      <= ncount_in;
      product_ff     <= product_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_ncount_ff  <= rsp_ncount_in;
      rsp_product_ff <= rsp_product_in;
      rsp_ecount_ff  <= rsp_ecount_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_status_ff;
   assign rsp_chan.neighbour_count   = rsp_ncount_ff;
   assign rsp_chan.neighbour_product = rsp_product_ff;
   assign rsp_chan.entry_count       = rsp_ecount_ff;

   // occupancy bound
   `SUSN_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(susn_pkg::CAPACITY))
   // RAM is only written while a transaction is in flight
   `SUSN_ASSERT_ALWAYS(a_no_idle_write, !(ram_we && state_ff == susn_pkg::ST_IDLE))
   // count only moves inside an operation
   `SUSN_ASSERT_NEXT(a_idle_count, state_ff == susn_pkg::ST_IDLE, $stable(count_ff))
   // final insert write grows the set by exactly one
   `SUSN_ASSERT_NEXT(a_insert_grow,
      state_ff == susn_pkg::ST_INS_SHIFT && !(idx_ff > lo_ff),
      count_ff == $past(count_ff) + CNT_W'(1))
   // accepted request leaves idle
   `SUSN_ASSERT_NEXT(a_accept_busy, req_fire, state_ff == susn_pkg::ST_SEARCH)

endmodule
